// ----- rtl/core/gpc_pkg.sv -----
package gpc_pkg;

   localparam int MAX_COLS       = 1024;
   localparam int COL_BITS       = $clog2(MAX_COLS);
   localparam int MAX_ROWS       = 65536;
   localparam int ROW_BITS       = $clog2(MAX_ROWS);
   localparam int COUNT_BITS     = 31;
   localparam int GRID_COLS_BITS = 11;
   localparam int GRID_ROWS_BITS = 17;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic REG_GRID_COLS = 1'b0;
   localparam logic REG_GRID_ROWS = 1'b1;

   typedef struct packed {
      logic                obstacle;
      logic [COL_BITS-1:0] col;
      logic                top_row;
      logic                left_edge;
      logic                start;
      logic                last;
   } cell_type;

endpackage

// ----- rtl/core/gpc_front.sv -----
module gpc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  logic [gpc_pkg::GRID_COLS_BITS-1:0]    grid_cols,
   input  logic [gpc_pkg::GRID_ROWS_BITS-1:0]    grid_rows,
   input  logic                                  req_valid,
   input  logic                                  req_obstacle,
   output logic                                  req_stall,
   output logic                                  q_push,
   output gpc_pkg::cell_type                     q_cell,
   input  logic                                  q_full
);

   logic [gpc_pkg::COL_BITS-1:0] col_ff, col_in, cols_m1;
   logic [gpc_pkg::ROW_BITS-1:0] row_ff, row_in, rows_m1;
   logic                         accept, col_end, last;

   always_comb begin
      if (grid_cols == '0) begin
         cols_m1 = '0;
      end else if (grid_cols > gpc_pkg::GRID_COLS_BITS'(gpc_pkg::MAX_COLS)) begin
         cols_m1 = gpc_pkg::COL_BITS'(gpc_pkg::MAX_COLS - 1);
      end else begin
         cols_m1 = gpc_pkg::COL_BITS'(grid_cols - gpc_pkg::GRID_COLS_BITS'(1));
      end
      if (grid_rows == '0) begin
         rows_m1 = '0;
      end else if (grid_rows > gpc_pkg::GRID_ROWS_BITS'(gpc_pkg::MAX_ROWS)) begin
         rows_m1 = gpc_pkg::ROW_BITS'(gpc_pkg::MAX_ROWS - 1);
      end else begin
         rows_m1 = gpc_pkg::ROW_BITS'(grid_rows - gpc_pkg::GRID_ROWS_BITS'(1));
      end
   end

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign q_push    = accept;
   assign col_end   = (col_ff == cols_m1);
   assign last      = col_end && (row_ff == rows_m1);

   always_comb begin
      q_cell.obstacle  = req_obstacle;
      q_cell.col       = col_ff;
      q_cell.top_row   = (row_ff == '0);
      q_cell.left_edge = (col_ff == '0);
      q_cell.start     = (row_ff == '0) && (col_ff == '0);
      q_cell.last      = last;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_end) begin
            col_in = '0;
            row_in = row_ff + gpc_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + gpc_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- rtl/core/gpc_queue.sv -----
module gpc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpc_pkg::cell_type push_cell,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output gpc_pkg::cell_type pop_cell
);

   gpc_pkg::cell_type                  slot_ff [gpc_pkg::QUEUE_DEPTH];
   logic [gpc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [gpc_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (gpc_pkg::QUEUE_PTR_BITS+1)'(gpc_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_cell = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (gpc_pkg::QUEUE_PTR_BITS+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (gpc_pkg::QUEUE_PTR_BITS+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cell;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + gpc_pkg::QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + gpc_pkg::QUEUE_PTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Queue written while full.");

   assert property (@(posedge clock) disable iff (reset) !(pop && !valid))
      else $error("Queue read while empty.");

endmodule

// ----- rtl/core/gpc_back.sv -----
module gpc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              restart,
   input  logic                              q_valid,
   input  gpc_pkg::cell_type                 q_cell,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gpc_pkg::COUNT_BITS-1:0]    rsp_path_count,
   output logic                              rsp_saturated,
   output logic                              rsp_last_cell
);

   logic [gpc_pkg::COUNT_BITS-1:0] row_mem [gpc_pkg::MAX_COLS];

   gpc_pkg::cell_type              stage_ff;
   logic                           stage_valid_ff;
   logic [gpc_pkg::COUNT_BITS-1:0] mem_rd_ff;
   logic                           fwd_hit_ff;
   logic [gpc_pkg::COUNT_BITS-1:0] fwd_data_ff;
   logic [gpc_pkg::COUNT_BITS-1:0] left_ff;
   logic                           sat_ff, sat_in;
   logic                           rsp_valid_ff;
   logic [gpc_pkg::COUNT_BITS-1:0] rsp_count_ff;
   logic                           rsp_sat_ff, rsp_last_ff;

   logic                           out_free, stage_adv, stage_free;
   logic [gpc_pkg::COUNT_BITS-1:0] above, left, count;
   logic [gpc_pkg::COUNT_BITS:0]   sum;
   logic                           overflow;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign stage_adv  = stage_valid_ff && out_free;
   assign stage_free = !stage_valid_ff || out_free;
   assign q_pop      = q_valid && stage_free;

   always_comb begin
      above    = stage_ff.top_row ? '0 : (fwd_hit_ff ? fwd_data_ff : mem_rd_ff);
      left     = stage_ff.left_edge ? '0 : left_ff;
      sum      = {1'b0, above} + {1'b0, left};
      overflow = 1'b0;
      if (stage_ff.obstacle) begin
         count = '0;
      end else if (stage_ff.start) begin
         count = gpc_pkg::COUNT_BITS'(1);
      end else if (sum[gpc_pkg::COUNT_BITS]) begin
         count    = '1;
         overflow = 1'b1;
      end else begin
         count = sum[gpc_pkg::COUNT_BITS-1:0];
      end
      sat_in = sat_ff || overflow;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         stage_ff    <= q_cell;
         mem_rd_ff   <= row_mem[q_cell.col];
         fwd_hit_ff  <= stage_adv && (stage_ff.col == q_cell.col);
         fwd_data_ff <= count;
      end
      if (stage_adv) begin
         row_mem[stage_ff.col] <= count;
         left_ff               <= count;
         rsp_count_ff          <= count;
         rsp_sat_ff            <= sat_in;
         rsp_last_ff           <= stage_ff.last;
      end
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         sat_ff         <= 1'b0;
      end else begin
         if (stage_free) begin
            stage_valid_ff <= q_valid;
         end
         if (stage_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (restart) begin
            sat_ff <= 1'b0;
         end else if (stage_adv) begin
            sat_ff <= stage_ff.last ? 1'b0 : sat_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign rsp_last_cell  = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (stage_adv && stage_ff.last) |=> !sat_ff)
      else $error("Saturation flag survived the end of a grid.");

   assert property (@(posedge clock) disable iff (reset)
      (stage_adv && stage_ff.start && !stage_ff.obstacle)
         |=> (rsp_path_count == gpc_pkg::COUNT_BITS'(1)))
      else $error("Free start cell did not count one path.");

endmodule

// ----- rtl/core/grid_path_count_obstacles.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_obstacle
// rsp       out        rsp_valid / rsp_stall  rsp_path_count, rsp_saturated, rsp_last_cell
// csr       in/out     psel, penable, pready  paddr, pwrite, pwdata, prdata
//
// One cell per cycle is sustained unless rsp stalls; the single row buffer port pair (one
// read and one write per cell) sets that rate. A taken cell passes the queue, stage and
// rsp registers. Reset is synchronous; the row buffer is not cleared, since each entry
// is written before it is read within a grid. A register write restarts the grid at the
// top-left cell. A stalled rsp fills a short queue, after which req_stall rises.
module grid_path_count_obstacles (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_obstacle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gpc_pkg::COUNT_BITS-1:0]       rsp_path_count,
   output logic                                 rsp_saturated,
   output logic                                 rsp_last_cell,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gpc_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [gpc_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [gpc_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready
);

   logic [gpc_pkg::GRID_COLS_BITS-1:0] grid_cols_ff;
   logic [gpc_pkg::GRID_ROWS_BITS-1:0] grid_rows_ff;
   logic                               csr_write, reg_sel;
   logic                               q_push, q_full, q_pop, q_valid;
   gpc_pkg::cell_type                  push_cell, pop_cell;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= gpc_pkg::GRID_COLS_BITS'(1);
         grid_rows_ff <= gpc_pkg::GRID_ROWS_BITS'(1);
      end else if (csr_write) begin
         unique case (reg_sel)
            gpc_pkg::REG_GRID_COLS: begin
               grid_cols_ff <= pwdata[gpc_pkg::GRID_COLS_BITS-1:0];
            end
            gpc_pkg::REG_GRID_ROWS: begin
               grid_rows_ff <= pwdata[gpc_pkg::GRID_ROWS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         gpc_pkg::REG_GRID_COLS: prdata = gpc_pkg::CSR_DATA_BITS'(grid_cols_ff);
         gpc_pkg::REG_GRID_ROWS: prdata = gpc_pkg::CSR_DATA_BITS'(grid_rows_ff);
         default:                prdata = '0;
      endcase
   end

   gpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write),
      .grid_cols    (grid_cols_ff),
      .grid_rows    (grid_rows_ff),
      .req_valid    (req_valid),
      .req_obstacle (req_obstacle),
      .req_stall    (req_stall),
      .q_push       (q_push),
      .q_cell       (push_cell),
      .q_full       (q_full)
   );

   gpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cell (push_cell),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_cell  (pop_cell)
   );

   gpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .restart        (csr_write),
      .q_valid        (q_valid),
      .q_cell         (pop_cell),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_path_count (rsp_path_count),
      .rsp_saturated  (rsp_saturated),
      .rsp_last_cell  (rsp_last_cell)
   );

endmodule
